// ===== rtl/core/tka_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tka_pkg
// Shared constants, types and register codes for the trim key auto-repeat
// block.
// ----------------------------------------------------------------------------
package tka_pkg;

  // Key and trim geometry
  localparam int NUM_KEYS  = 8;
  localparam int NUM_TRIMS = NUM_KEYS / 2;
  localparam int TRIM_W    = 8;
  localparam int TICK_W    = 16;

  // Auto-repeat period in ticks (1..255)
  localparam int REPEAT_PERIOD = 30;

  // elapsed / 10 as (elapsed * 205) >> 11, exact for 8-bit inputs
  localparam int ELAPSED_W   = 8;
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_PROD_W = 16;
  localparam int ADD_W       = 5;

  // Divisibility test: n % P == 0 iff (n * ceil(2^F / P)) mod 2^F < ceil(2^F / P)
  // F covers the tick width plus the period width.
  localparam int MOD_FRAC_W = TICK_W + 8;
  localparam int MOD_MUL_W  = MOD_FRAC_W + 1;
  localparam int MOD_PROD_W = TICK_W + MOD_MUL_W;
  localparam logic [MOD_MUL_W-1:0] MOD_MUL =
    MOD_MUL_W'(((64'd1 << MOD_FRAC_W) + 64'(REPEAT_PERIOD) - 64'd1) / 64'(REPEAT_PERIOD));

  // Configuration register widths
  localparam int STEP_W  = 5;
  localparam int LIMIT_W = 7;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Reset values
  localparam logic [NUM_KEYS-1:0] KEY_MASK_RST     = 8'd255;
  localparam logic [TICK_W-1:0]   PRESS_MIN_RST    = 16'd10;
  localparam logic [TICK_W-1:0]   REPEAT_DELAY_RST = 16'd50;
  localparam logic [STEP_W-1:0]   TRIM_STEP_RST    = 5'd4;
  localparam logic [LIMIT_W-1:0]  TRIM_LIMIT_RST   = 7'd100;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_KEY_MASK     = 3'd0,
    REG_PRESS_MIN    = 3'd1,
    REG_REPEAT_DELAY = 3'd2,
    REG_TRIM_STEP    = 3'd3,
    REG_TRIM_LIMIT   = 3'd4
  } reg_idx_t;

  // Item kinds carried on tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Timing thresholds shared by all key lanes
  typedef struct packed {
    logic [TICK_W-1:0] press_min;
    logic [TICK_W-1:0] repeat_delay;
  } key_cfg_t;

  // Per-key status back to the top level
  typedef struct packed {
    logic key_event;
    logic repeating;
  } key_stat_t;

endpackage : tka_pkg
`default_nettype wire

// ===== rtl/core/tka_key.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tka_key
// One key lane: released / pressed / repeating machine with a wrapping
// 16-bit tick counter. Steps once per tick item.
// ----------------------------------------------------------------------------
module tka_key
  import tka_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             tick_en,
  input  wire logic             down,
  input  wire logic [ADD_W-1:0] add,
  input  wire key_cfg_t         cfg,
  output key_stat_t             stat
);

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_REPEAT   = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [TICK_W-1:0]   ticks_sum;
  logic [MOD_PROD_W-1:0] mod_prod;
  logic                on_period;
  logic                fire_event;

  // Counter advance, wraps at 16 bits
  assign ticks_sum = ticks_r + TICK_W'(add);

  // Repeat period hit: multiply by the period's inverse, check the fraction
  assign mod_prod  = MOD_PROD_W'(ticks_sum) * MOD_PROD_W'(MOD_MUL);
  assign on_period = {1'b0, mod_prod[MOD_FRAC_W-1:0]} < MOD_MUL;

  // Next state and event
  always_comb begin
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    fire_event = 1'b0;
    if (tick_en) begin
      ticks_nxt = ticks_sum;
      case (phase_r)
        PH_RELEASED: begin
          if (down && ticks_sum >= cfg.press_min) begin
            phase_nxt = PH_PRESSED;
            ticks_nxt = '0;
          end
        end
        PH_PRESSED: begin
          if (down) begin
            if (ticks_sum >= cfg.repeat_delay) begin
              fire_event = 1'b1;
              phase_nxt  = PH_REPEAT;
            end
          end else begin
            fire_event = ticks_sum >= cfg.press_min;
            phase_nxt  = PH_RELEASED;
            ticks_nxt  = '0;
          end
        end
        PH_REPEAT: begin
          if (down) begin
            fire_event = on_period;
          end else begin
            phase_nxt = PH_RELEASED;
            ticks_nxt = '0;
          end
        end
        // unused phase code: machine holds, counter still advances
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      ticks_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  assign stat.key_event = fire_event;
  assign stat.repeating = (phase_nxt == PH_REPEAT);

endmodule : tka_key
`default_nettype wire

// ===== rtl/core/trim_key_auto_repeat_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trim_key_auto_repeat_top
// Eight debounced trim keys with auto repeat driving four clamped trims.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_tuser is the command (tick or load).
//           A tick samples the eight keys and advances every key counter by
//           elapsed_time / 10; a load writes one trim value as given.
//   out_* : one result per item: the four trims, the keys that fired an
//           event on this item and the keys now in auto repeat.
//   cfg_* : register port, a setup and an access phase per write,
//           always ready. Write registers only while the block is idle.
// Timing:
//   An accepted item passes through an input register, then the key
//   machines and trim adders feed the output register. One item per
//   cycle is sustained while out_tready keeps up; the key and trim state
//   closes its loop within the compute stage.
// Reset: all keys released, counters and trims zero, registers at defaults,
//   both pipeline stages empty.
// Stall: while out_tvalid is high and out_tready low the whole pipe holds
//   and in_tready drops; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module trim_key_auto_repeat_top
  import tka_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [7:0] key_pressed, [15:8] elapsed_time, [17:16] trim_index,
  // [25:18] trim_value, [31:26] zero
  input  wire logic [31:0]           in_tdata,
  // [0] cmd
  input  wire logic                  in_tuser,
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] trim_0, [15:8] trim_1, [23:16] trim_2, [31:24] trim_3,
  // [39:32] key_events, [47:40] repeating_keys
  output logic [47:0]                out_tdata,
  // Configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  // Configuration registers
  logic [NUM_KEYS-1:0] key_mask_r;
  logic [TICK_W-1:0]   press_min_r;
  logic [TICK_W-1:0]   repeat_delay_r;
  logic [STEP_W-1:0]   trim_step_r;
  logic [LIMIT_W-1:0]  trim_limit_r;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;
  key_cfg_t            key_cfg;

  // Input stage
  logic                          s1_valid_r;
  logic                          s1_cmd_r;
  logic [NUM_KEYS-1:0]           s1_keys_r;
  logic [ADD_W-1:0]              s1_add_r;
  logic [1:0]                    s1_idx_r;
  logic signed [TRIM_W-1:0]      s1_val_r;
  logic [DIV10_PROD_W-1:0]       div10_prod;

  // Compute stage and output register
  logic                          advance;
  logic                          fire;
  logic                          tick;
  key_stat_t                     key_stat [NUM_KEYS];
  logic [NUM_KEYS-1:0]           key_ev;
  logic [NUM_KEYS-1:0]           key_rep;
  logic signed [TRIM_W-1:0]      trim_r   [NUM_TRIMS];
  logic signed [TRIM_W-1:0]      trim_nxt [NUM_TRIMS];
  logic                          out_valid_r;
  logic [47:0]                   out_data_r;

  // One key event applied to a trim: wide add, then clamp to +-limit
  function automatic logic signed [TRIM_W-1:0] apply_trim(
    input logic signed [TRIM_W-1:0] v,
    input logic                     up,
    input logic [STEP_W-1:0]        step,
    input logic [LIMIT_W-1:0]       lim
  );
    logic signed [TRIM_W+1:0] vx;
    logic signed [TRIM_W+1:0] step_s;
    logic signed [TRIM_W+1:0] lim_s;
    logic signed [TRIM_W+1:0] sum;
    vx     = {{2{v[TRIM_W-1]}}, v};
    step_s = $signed({{(TRIM_W+2-STEP_W){1'b0}}, step});
    lim_s  = $signed({{(TRIM_W+2-LIMIT_W){1'b0}}, lim});
    sum    = up ? (vx + step_s) : (vx - step_s);
    if (sum > lim_s) sum = lim_s;
    if (sum < -lim_s) sum = -lim_s;
    return sum[TRIM_W-1:0];
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mask_r     <= KEY_MASK_RST;
      press_min_r    <= PRESS_MIN_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
      trim_step_r    <= TRIM_STEP_RST;
      trim_limit_r   <= TRIM_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_MASK:     key_mask_r     <= cfg_pwdata[NUM_KEYS-1:0];
        REG_PRESS_MIN:    press_min_r    <= cfg_pwdata[TICK_W-1:0];
        REG_REPEAT_DELAY: repeat_delay_r <= cfg_pwdata[TICK_W-1:0];
        REG_TRIM_STEP:    trim_step_r    <= cfg_pwdata[STEP_W-1:0];
        REG_TRIM_LIMIT:   trim_limit_r   <= cfg_pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_KEY_MASK:     cfg_prdata = CFG_DATA_W'(key_mask_r);
      REG_PRESS_MIN:    cfg_prdata = CFG_DATA_W'(press_min_r);
      REG_REPEAT_DELAY: cfg_prdata = CFG_DATA_W'(repeat_delay_r);
      REG_TRIM_STEP:    cfg_prdata = CFG_DATA_W'(trim_step_r);
      REG_TRIM_LIMIT:   cfg_prdata = CFG_DATA_W'(trim_limit_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign key_cfg.press_min    = press_min_r;
  assign key_cfg.repeat_delay = repeat_delay_r;

  // ---------------- pipeline control ----------------
  // Whole pipe moves unless a finished result is waiting and not taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign fire      = advance && s1_valid_r;
  assign tick      = fire && (s1_cmd_r == CMD_TICK);

  // ---------------- input stage ----------------
  // elapsed / 10 by reciprocal multiply
  assign div10_prod = DIV10_PROD_W'(in_tdata[15:8]) * DIV10_PROD_W'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_keys_r <= in_tdata[7:0] & key_mask_r;
      s1_add_r  <= div10_prod[DIV10_SHIFT +: ADD_W];
      s1_idx_r  <= in_tdata[17:16];
      s1_val_r  <= $signed(in_tdata[25:18]);
    end
  end

  // ---------------- key lanes ----------------
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    tka_key u_key (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick_en (tick),
      .down    (s1_keys_r[k]),
      .add     (s1_add_r),
      .cfg     (key_cfg),
      .stat    (key_stat[k])
    );
    assign key_ev[k]  = key_stat[k].key_event;
    assign key_rep[k] = key_stat[k].repeating;
  end

  // ---------------- trim update ----------------
  // Per trim: even key first, then odd key. Trim 0 runs in reverse.
  always_comb begin
    logic signed [TRIM_W-1:0] v;
    for (int p = 0; p < NUM_TRIMS; p++) begin
      v = trim_r[p];
      if (tick) begin
        if (key_ev[2*p])   v = apply_trim(v, p == 0, trim_step_r, trim_limit_r);
        if (key_ev[2*p+1]) v = apply_trim(v, p != 0, trim_step_r, trim_limit_r);
      end else if (fire && (32'(s1_idx_r) == 32'(p))) begin
        v = s1_val_r;
      end
      trim_nxt[p] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_TRIMS; p++) trim_r[p] <= '0;
    end else begin
      for (int p = 0; p < NUM_TRIMS; p++) trim_r[p] <= trim_nxt[p];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {key_rep, key_ev,
                     trim_nxt[3], trim_nxt[2], trim_nxt[1], trim_nxt[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : trim_key_auto_repeat_top
`default_nettype wire

// ===== rtl/core/tka_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tka_checker
// Port-level checks for the trim key auto-repeat block, bound to the top.
// ----------------------------------------------------------------------------
module tka_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [47:0]           out_tdata
);

  // Result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // Input only backs up when a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

  // Accepted item reaches the output when the receiver keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing two cycles after transfer");

  // Pipe empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule : tka_checker

bind trim_key_auto_repeat_top tka_checker u_tka_checker (.*);
`default_nettype wire
